// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the decoder RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/itx_pkg.sv =====
// ---------------------------------------------------------------------------
// itx_pkg
// Types, constants and helpers of the indexed texture pixel decoder.
// ---------------------------------------------------------------------------
package itx_pkg;

  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 25;

  typedef enum logic [2:0] {
    MODE_RGB16 = 3'd0,
    MODE_RGB24 = 3'd1,
    MODE_RGB32 = 3'd2,
    MODE_IDX4  = 3'd3,
    MODE_IDX8  = 3'd4
  } img_mode_t;

  typedef enum logic [1:0] {
    PFMT_RGB16 = 2'd0,
    PFMT_RGB32 = 2'd1
  } pal_fmt_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_MODE     = 2'd0,
    CFG_PALETTE_FORMAT = 2'd1,
    CFG_PALETTE_BYTES  = 2'd2,
    CFG_PIXEL_COUNT    = 2'd3
  } cfg_idx_t;

  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_PIXEL     = 1'b1;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  function automatic rgba_t from_a1b5g5r5(input logic [15:0] c);
    rgba_t px;
    px.red   = {c[4:0], 3'b000};
    px.green = {c[9:5], 3'b000};
    px.blue  = {c[14:10], 3'b000};
    px.alpha = c[15] ? 8'hff : 8'h00;
    return px;
  endfunction

endpackage

// ===== src/itx_palette_ram.sv =====
// ---------------------------------------------------------------------------
// itx_palette_ram
// Palette store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module itx_palette_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [itx_pkg::PAL_AW-1:0] waddr,
  input  logic [31:0]               wdata,
  input  logic                      re,
  input  logic [itx_pkg::PAL_AW-1:0] raddr0,
  input  logic [itx_pkg::PAL_AW-1:0] raddr1,
  output logic [31:0]               rdata0,
  output logic [31:0]               rdata1
);
  import itx_pkg::*;

  logic [31:0] mem [PAL_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== src/indexed_texture_pixel_decoder.sv =====
// ---------------------------------------------------------------------------
// indexed_texture_pixel_decoder
// Decodes streamed texture beats into RGBA8888 pixels.
// ---------------------------------------------------------------------------
// Input beats carry either a palette entry write (tuser 0) or one pixel word
// (tuser 1). Palette writes produce nothing; pixel words produce one pixel, or
// two in 4-bit indexed mode (low nibble first). Output beats carry RGBA8888
// and tlast on the final pixel of the picture; the pixel counter then wraps.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata; the
// user writes them only while the stream is idle, which the block does not enforce.
// An accepted pixel beat is registered in the palette read register, then in
// the output register, from which it shows on the output.
// Throughput: one beat per cycle unless the output stalls; a 4-bit indexed
// beat occupies the decode stage once per nibble, or only for the low nibble
// when that nibble ends the picture.
// Reset clears the registers to their defaults, the pixel counter and both
// pipeline stages; palette contents are kept undefined until written.
// When out_tready is low the output register holds, the decode stage fills,
// and in_tready drops until a result moves on.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_texture_pixel_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] palette_index, [39:8] data_word
  input  logic [itx_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] opcode
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic [itx_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [itx_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [itx_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import itx_pkg::*;

  localparam logic [8:0] DEPTH_LIM = 9'(PAL_DEPTH);

  // configuration
  logic [2:0]  mode_r;
  logic [1:0]  fmt_r;
  logic [10:0] pbytes_r;
  logic [24:0] pcount_r;

  // decode stage
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_phase_r, s1_phase_nxt;
  logic [31:0] s1_word_r;
  logic [31:0] q0, q1;

  // output stage
  logic        out_valid_r, out_valid_nxt;
  rgba_t       out_px_r;
  logic        out_last_r;

  logic [24:0] cnt_r, cnt_nxt;

  logic        in_fire;
  logic [7:0]  in_pidx;
  logic [31:0] in_word;
  logic        pal_we, pal_re;
  logic [PAL_AW-1:0] raddr0, raddr1;

  logic        s1_adv, s1_two, s1_done;
  logic        cnt_over, cnt_last;
  logic [7:0]  idx;
  logic [31:0] entry;
  rgba_t       lut_px, px;

  assign in_pidx = in_tdata[7:0];
  assign in_word = in_tdata[39:8];
  assign in_fire = in_tvalid && in_tready;

  assign pal_we = in_fire && (in_tuser == OP_PAL_WRITE) && ({1'b0, in_pidx} < DEPTH_LIM);
  assign pal_re = in_fire && (in_tuser == OP_PIXEL);
  assign raddr0 = (mode_r == MODE_IDX8) ? PAL_AW'(in_word[7:0]) : PAL_AW'(in_word[3:0]);
  assign raddr1 = PAL_AW'(in_word[7:4]);

  itx_palette_ram u_pal (
    .clk    (clk),
    .we     (pal_we),
    .waddr  (PAL_AW'(in_pidx)),
    .wdata  (in_word),
    .re     (pal_re),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (q0),
    .rdata1 (q1)
  );

  // pixel counter
  assign cnt_over = cnt_r >= pcount_r;
  assign cnt_last = ({1'b0, cnt_r} + 26'd1) == {1'b0, pcount_r};

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_two  = (mode_r == MODE_IDX4) && !s1_phase_r;
  assign s1_done = s1_adv && (!s1_two || (!cnt_over && cnt_last));
  assign in_tready = !s1_valid_r || s1_done;

  // palette lookup
  always_comb begin
    if (s1_phase_r) begin
      idx = {4'h0, s1_word_r[7:4]};
    end else if (mode_r == MODE_IDX8) begin
      idx = s1_word_r[7:0];
    end else begin
      idx = {4'h0, s1_word_r[3:0]};
    end
    entry  = s1_phase_r ? q1 : q0;
    lut_px = '0;
    if ({1'b0, idx} < DEPTH_LIM) begin
      case (fmt_r)
        PFMT_RGB32: begin
          if ({1'b0, idx, 2'b11} < pbytes_r) begin
            lut_px = entry;
          end
        end
        PFMT_RGB16: begin
          if ({2'b00, idx, 1'b1} < pbytes_r) begin
            lut_px = from_a1b5g5r5(entry[15:0]);
          end
        end
        default: lut_px = '0;
      endcase
    end
  end

  always_comb begin
    case (mode_r)
      MODE_RGB16: px = from_a1b5g5r5(s1_word_r[15:0]);
      MODE_RGB24: px = {8'hff, s1_word_r[23:0]};
      MODE_RGB32: px = s1_word_r;
      MODE_IDX4:  px = lut_px;
      MODE_IDX8:  px = lut_px;
      default:    px = '0;
    endcase
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_phase_nxt  = s1_phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cnt_nxt       = cnt_r;
    if (!s1_valid_r || s1_done) begin
      s1_valid_nxt = in_fire && (in_tuser == OP_PIXEL);
      s1_phase_nxt = 1'b0;
    end else if (s1_adv) begin
      s1_phase_nxt = 1'b1;
    end
    if (s1_adv) begin
      if (cnt_over || cnt_last) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 25'd1;
      end
      if (!cnt_over) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RGB16;
      fmt_r       <= PFMT_RGB16;
      pbytes_r    <= '0;
      pcount_r    <= 25'd1;
      s1_valid_r  <= 1'b0;
      s1_phase_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IMAGE_MODE:     mode_r   <= cfg_wdata[2:0];
          CFG_PALETTE_FORMAT: fmt_r    <= cfg_wdata[1:0];
          CFG_PALETTE_BYTES:  pbytes_r <= cfg_wdata[10:0];
          CFG_PIXEL_COUNT:    pcount_r <= cfg_wdata[24:0];
          default: ;
        endcase
      end
      s1_valid_r  <= s1_valid_nxt;
      s1_phase_r  <= s1_phase_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    if (pal_re) begin
      s1_word_r <= in_word;
    end
    if (s1_adv && !cnt_over) begin
      out_px_r   <= px;
      out_last_r <= cnt_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_px_r;
  assign out_tlast  = out_last_r;

  `ASSERT_IMP(a_phase_needs_item, s1_phase_r, s1_valid_r && (mode_r == MODE_IDX4))
  `ASSERT_IMP(a_accept_frees_stage, in_fire && s1_valid_r, s1_done)
  `ASSERT_IMP(a_last_clears_count, out_valid_r && out_last_r, cnt_r == '0)
  `ASSERT_NEXT(a_stall_holds_stage, s1_valid_r && out_valid_r && !out_tready, s1_valid_r)

endmodule

// ===== dv/tb_indexed_texture_pixel_decoder.sv =====
// ---------------------------------------------------------------------------
// tb_indexed_texture_pixel_decoder
// Self-checking bench for the texture pixel decoder. A short table of
// directed beats and register writes runs first: extremes, every image and
// palette mode, out-of-range indices, dropped high nibble, counter overrun and
// zero pixel count. Random phases with fresh register settings follow. A local
// decoder model predicts the unpinned pixels. Results are compared field by
// field, in order, while both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_indexed_texture_pixel_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import itx_pkg::*;

  localparam logic [2:0] MODE_RSVD5  = 3'd5;
  localparam logic [2:0] MODE_RSVD7  = 3'd7;
  localparam logic [1:0] PFMT_UNSUP  = 2'd2;
  localparam logic [1:0] PFMT_UNSUP3 = 2'd3;

  localparam int N_DIR     = 40;
  localparam int N_PHASE   = 14;
  localparam int PHASE_LEN = 28;
  localparam int LAT_PAD   = 6;
  localparam int CHOKE_CYC = 40;

  typedef struct packed {
    logic  last;
    rgba_t px;
  } texel_t;

  typedef enum logic [1:0] {ROW_SET, ROW_RUN, ROW_PIN} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    reg_sel;
    logic        op;
    logic [7:0]  pidx;
    logic [31:0] word;
    texel_t      want;
  } vec_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = CFG_IMAGE_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // decoder model state
  logic [31:0] pal_mem [PAL_DEPTH];
  bit          pal_known [PAL_DEPTH];
  logic [2:0]  mode_q   = MODE_RGB16;
  logic [1:0]  fmt_q    = PFMT_RGB16;
  logic [10:0] pbytes_q = '0;
  logic [24:0] pcount_q = 25'd1;
  logic [24:0] count_q  = '0;

  texel_t due_pixels [$];
  int     mismatches = 0;
  bit     src_idle   = 1'b1;
  bit     sink_idle  = 1'b1;
  bit     choke_req  = 1'b0;

  vec_t dir_tab [N_DIR] = '{
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h00, 32'h0000_0000,       33'h1_0000_0000},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'hff, 32'h0000_ffff,       33'h1_fff8_f8f8},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h5a, 32'hffff_8000,       33'h1_ff00_0000},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'ha5, 32'h0000_7c1f,       33'h1_00f8_00f8},
    '{ROW_SET, CFG_IMAGE_MODE,     OP_PAL_WRITE, 8'h00, 32'(MODE_RGB24),     33'h0},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h00, 32'hffff_ffff,       33'h1_ffff_ffff},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'hff, 32'h0000_0000,       33'h1_ff00_0000},
    '{ROW_SET, CFG_IMAGE_MODE,     OP_PAL_WRITE, 8'h00, 32'(MODE_RGB32),     33'h0},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h3c, 32'h8040_2010,       33'h1_8040_2010},
    '{ROW_SET, CFG_IMAGE_MODE,     OP_PAL_WRITE, 8'h00, 32'(MODE_RSVD7),     33'h0},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'hc3, 32'hffff_ffff,       33'h1_0000_0000},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PAL_WRITE, 8'h00, 32'h0000_ffff,       33'h0},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PAL_WRITE, 8'h01, 32'h8040_2010,       33'h0},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PAL_WRITE, 8'hff, 32'hffff_ffff,       33'h0},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PAL_WRITE, 8'h0f, 32'h0000_7c1f,       33'h0},
    '{ROW_SET, CFG_IMAGE_MODE,     OP_PAL_WRITE, 8'h00, 32'(MODE_IDX8),      33'h0},
    '{ROW_SET, CFG_PALETTE_FORMAT, OP_PAL_WRITE, 8'h00, 32'(PFMT_RGB32),     33'h0},
    '{ROW_SET, CFG_PALETTE_BYTES,  OP_PAL_WRITE, 8'h00, 32'd1024,            33'h0},
    '{ROW_SET, CFG_PIXEL_COUNT,    OP_PAL_WRITE, 8'h00, 32'd4,               33'h0},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h77, 32'hffff_ff01,       33'h0_8040_2010},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h88, 32'h0000_00ff,       33'h0_ffff_ffff},
    '{ROW_SET, CFG_PALETTE_FORMAT, OP_PAL_WRITE, 8'h00, 32'(PFMT_RGB16),     33'h0},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h11, 32'h0000_0000,       33'h0_fff8_f8f8},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h22, 32'h0000_00ff,       33'h1_fff8_f8f8},
    '{ROW_SET, CFG_PALETTE_BYTES,  OP_PAL_WRITE, 8'h00, 32'd510,             33'h0},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h33, 32'h0000_00ff,       33'h0_0000_0000},
    '{ROW_SET, CFG_PALETTE_FORMAT, OP_PAL_WRITE, 8'h00, 32'(PFMT_UNSUP),     33'h0},
    '{ROW_PIN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h44, 32'h0000_0001,       33'h0_0000_0000},
    '{ROW_SET, CFG_IMAGE_MODE,     OP_PAL_WRITE, 8'h00, 32'(MODE_IDX4),      33'h0},
    '{ROW_SET, CFG_PALETTE_FORMAT, OP_PAL_WRITE, 8'h00, 32'(PFMT_RGB32),     33'h0},
    '{ROW_SET, CFG_PALETTE_BYTES,  OP_PAL_WRITE, 8'h00, 32'd1024,            33'h0},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h55, 32'h0000_00f1,       33'h0},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h66, 32'h0000_001f,       33'h0},
    '{ROW_SET, CFG_PIXEL_COUNT,    OP_PAL_WRITE, 8'h00, 32'd3,               33'h0},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PIXEL,     8'h99, 32'h0000_00f0,       33'h0},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PIXEL,     8'haa, 32'h0000_0010,       33'h0},
    '{ROW_SET, CFG_PIXEL_COUNT,    OP_PAL_WRITE, 8'h00, 32'd1,               33'h0},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PIXEL,     8'hbb, 32'h0000_0010,       33'h0},
    '{ROW_SET, CFG_PIXEL_COUNT,    OP_PAL_WRITE, 8'h00, 32'd0,               33'h0},
    '{ROW_RUN, CFG_IMAGE_MODE,     OP_PIXEL,     8'hcc, 32'h0000_0010,       33'h0}
  };

  indexed_texture_pixel_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic rgba_t expand_555(input logic [15:0] c);
    rgba_t p;
    p.red   = 8'((c & 16'h001f) << 3);
    p.green = 8'(((c >> 5) & 16'h001f) << 3);
    p.blue  = 8'(((c >> 10) & 16'h001f) << 3);
    p.alpha = ((c & 16'h8000) != 0) ? 8'd255 : 8'd0;
    return p;
  endfunction

  function automatic rgba_t pal_color(input int unsigned idx);
    rgba_t       p;
    logic [31:0] e;
    p = '0;
    e = pal_mem[idx];
    if (fmt_q == PFMT_RGB32) begin
      if (idx * 4 + 3 < pbytes_q) p = e;
    end else if (fmt_q == PFMT_RGB16) begin
      if (idx * 2 + 1 < pbytes_q) p = expand_555(e[15:0]);
    end
    return p;
  endfunction

  // returns 1 when the pixel closed the picture
  function automatic bit tally_pixel(input rgba_t p, ref texel_t res [$]);
    if (count_q >= pcount_q) begin
      count_q = '0;
      return 1'b0;
    end
    if (count_q + 25'd1 == pcount_q) begin
      count_q = '0;
      res.insert(res.size(), {1'b1, p});
      return 1'b1;
    end
    count_q = count_q + 25'd1;
    res.insert(res.size(), {1'b0, p});
    return 1'b0;
  endfunction

  function automatic void decode_beat(input logic op, input logic [7:0] pidx,
                                      input logic [31:0] word, ref texel_t res [$]);
    rgba_t p;
    p = '0;
    if (op == OP_PAL_WRITE) begin
      pal_mem[pidx]   = word;
      pal_known[pidx] = 1'b1;
      return;
    end
    case (mode_q)
      MODE_RGB16: p = expand_555(word[15:0]);
      MODE_RGB24: p = {8'hff, word[23:0]};
      MODE_RGB32: p = word;
      MODE_IDX4: begin
        // high nibble is dropped once the low one ends the picture
        if (!tally_pixel(pal_color(word[3:0]), res))
          void'(tally_pixel(pal_color(word[7:4]), res));
        return;
      end
      MODE_IDX8: p = pal_color(word[7:0]);
      default: p = '0;
    endcase
    void'(tally_pixel(p, res));
  endfunction

  function automatic void check_field(input string label, input logic [7:0] want,
                                      input logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, seen);
      mismatches++;
    end
  endfunction

  task automatic push_beat(input logic op, input logic [7:0] pidx, input logic [31:0] word,
                           input bit pinned, input texel_t want);
    int     gap;
    texel_t got [$];
    gap = src_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {word, pidx};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    decode_beat(op, pidx, word, got);
    if (pinned) begin
      got.delete();
      got.insert(0, want);
    end
    foreach (got[k]) due_pixels.insert(due_pixels.size(), got[k]);
  endtask

  task automatic write_reg(input cfg_idx_t sel, input logic [24:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_pixels.size() != 0) @(negedge clk);
    repeat (LAT_PAD) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (sel)
      CFG_IMAGE_MODE:     mode_q   = val[2:0];
      CFG_PALETTE_FORMAT: fmt_q    = val[1:0];
      CFG_PALETTE_BYTES:  pbytes_q = val[10:0];
      default:            pcount_q = val;
    endcase
  endtask

  task automatic random_item();
    logic [31:0] w;
    logic [7:0]  ix;
    w  = $urandom;
    ix = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) begin
      push_beat(OP_PAL_WRITE, ix, w, 1'b0, '0);
      return;
    end
    // load the entry first so an 8-bit index never hits an unwritten one
    if (mode_q == MODE_IDX8 && !pal_known[w[7:0]])
      push_beat(OP_PAL_WRITE, w[7:0], $urandom, 1'b0, '0);
    push_beat(OP_PIXEL, ix, w, 1'b0, '0);
  endtask

  always @(posedge clk) begin : out_check
    texel_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        e = due_pixels.pop_front();
        check_field("red",   e.px.red,   out_tdata[7:0]);
        check_field("green", e.px.green, out_tdata[15:8]);
        check_field("blue",  e.px.blue,  out_tdata[23:16]);
        check_field("alpha", e.px.alpha, out_tdata[31:24]);
        check_field("last",  {7'd0, e.last}, {7'd0, out_tlast});
      end
    end
  end

  initial begin : sink
    int stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        out_tready <= 1'b0;
        repeat (CHOKE_CYC) @(negedge clk);
      end
      stall = sink_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stim
    logic [1:0]  fmt;
    logic [24:0] nbytes;
    logic [24:0] npix;
    logic [2:0]  mode_plan [N_PHASE];
    mode_plan = '{MODE_IDX4, MODE_IDX8, MODE_RGB16, MODE_IDX4, MODE_IDX8, MODE_RGB24,
                  MODE_IDX8, MODE_RGB32, MODE_RSVD5, MODE_IDX4, MODE_IDX8, MODE_RSVD7,
                  MODE_IDX4, MODE_IDX8};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      case (dir_tab[r].kind)
        ROW_SET: write_reg(dir_tab[r].reg_sel, dir_tab[r].word[24:0]);
        ROW_RUN: push_beat(dir_tab[r].op, dir_tab[r].pidx, dir_tab[r].word, 1'b0, '0);
        default: push_beat(dir_tab[r].op, dir_tab[r].pidx, dir_tab[r].word, 1'b1,
                           dir_tab[r].want);
      endcase
    end

    // entries reachable by a 4-bit index
    for (int i = 0; i < 16; i++)
      push_beat(OP_PAL_WRITE, 8'(i), $urandom, 1'b0, '0);

    for (int ph = 0; ph < N_PHASE; ph++) begin
      case ($urandom_range(0, 5))
        0:       fmt = PFMT_UNSUP;
        1:       fmt = PFMT_UNSUP3;
        2, 3:    fmt = PFMT_RGB16;
        default: fmt = PFMT_RGB32;
      endcase
      case (ph % 5)
        0:       nbytes = 25'd1024;
        1:       nbytes = 25'd0;
        2:       nbytes = 25'd2047;
        default: nbytes = 25'($urandom_range(16, 1024));
      endcase
      case (ph % 7)
        0:       npix = 25'd1;
        1:       npix = 25'd16777216;
        2:       npix = 25'h1ff_ffff;
        3:       npix = 25'd0;
        default: npix = 25'($urandom_range(2, 40));
      endcase
      write_reg(CFG_IMAGE_MODE, 25'(mode_plan[ph]));
      write_reg(CFG_PALETTE_FORMAT, 25'(fmt));
      write_reg(CFG_PALETTE_BYTES, nbytes);
      write_reg(CFG_PIXEL_COUNT, npix);
      src_idle  = (ph != 0) && ($urandom_range(0, 3) != 0);
      sink_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
      if (ph == 4) begin
        src_idle  = 1'b0;
        choke_req = 1'b1;
      end
      repeat (PHASE_LEN) random_item();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (LAT_PAD + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
